// ===== sv/ngga_pkg.sv =====
// ----------------------------------------------------------------------------
// ngga_pkg
// Shared types and constants for the GGA position parser.
// ----------------------------------------------------------------------------
package ngga_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [3:0] FIELD_MAX  = 4'd15;
  localparam logic [3:0] FIELD_TIME = 4'd1;
  localparam logic [3:0] FIELD_LAT  = 4'd2;
  localparam logic [3:0] FIELD_NS   = 4'd3;
  localparam logic [3:0] FIELD_LON  = 4'd4;
  localparam logic [3:0] FIELD_EW   = 4'd5;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       sentence_end;
  } char_t;

  typedef struct packed {
    logic [31:0] time_value;
    logic [31:0] latitude_value;
    logic [7:0]  north_south;
    logic [31:0] longitude_value;
    logic [7:0]  east_west;
    logic [3:0]  fields_seen;
    logic        bad_character;
  } fix_t;

  typedef enum logic [2:0] {
    OP_SKIP = 3'd0,
    OP_TIME = 3'd1,
    OP_LAT  = 3'd2,
    OP_LON  = 3'd3,
    OP_NS   = 3'd4,
    OP_EW   = 3'd5,
    OP_BAD  = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_byte;
    logic [3:0] fields_seen;
    logic       last;
  } item_t;

endpackage

// ===== sv/ngga_front.sv =====
// ----------------------------------------------------------------------------
// ngga_front
// Tracks the field index and classifies each character into a back-end op.
// ----------------------------------------------------------------------------
module ngga_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  ngga_pkg::char_t   char_data,
  output ngga_pkg::item_t   item
);

  logic [3:0] field_index;
  logic [3:0] field_index_next;
  logic       is_comma;
  logic       is_digit;
  logic       is_dot;
  ngga_pkg::op_t num_op;

  assign is_comma = (char_data.char_byte == ngga_pkg::CH_COMMA);
  assign is_dot   = (char_data.char_byte == ngga_pkg::CH_DOT);
  assign is_digit = (char_data.char_byte >= ngga_pkg::CH_ZERO) &&
                    (char_data.char_byte <= ngga_pkg::CH_NINE);

  always_comb begin
    field_index_next = field_index;
    if (is_comma && (field_index != ngga_pkg::FIELD_MAX)) begin
      field_index_next = field_index + 4'd1;
    end
  end

  always_comb begin
    unique case (field_index)
      ngga_pkg::FIELD_TIME: num_op = ngga_pkg::OP_TIME;
      ngga_pkg::FIELD_LAT:  num_op = ngga_pkg::OP_LAT;
      default:              num_op = ngga_pkg::OP_LON;
    endcase
  end

  always_comb begin
    item.char_byte   = char_data.char_byte;
    item.last        = char_data.sentence_end;
    item.fields_seen = field_index_next;
    item.op          = ngga_pkg::OP_SKIP;
    if (!is_comma) begin
      unique case (field_index)
        ngga_pkg::FIELD_TIME, ngga_pkg::FIELD_LAT, ngga_pkg::FIELD_LON: begin
          if (is_digit) begin
            item.op = num_op;
          end else if (!is_dot) begin
            item.op = ngga_pkg::OP_BAD;
          end
        end
        ngga_pkg::FIELD_NS: item.op = ngga_pkg::OP_NS;
        ngga_pkg::FIELD_EW: item.op = ngga_pkg::OP_EW;
        default:            item.op = ngga_pkg::OP_SKIP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index <= 4'd0;
    end else if (accept) begin
      field_index <= char_data.sentence_end ? 4'd0 : field_index_next;
    end
  end

  a_clear_at_end: assert property (@(posedge clk) disable iff (rst)
    accept && char_data.sentence_end |=> field_index == 4'd0)
    else $error("field index not cleared after sentence end");

  a_saturate: assert property (@(posedge clk) disable iff (rst)
    accept && !char_data.sentence_end && $past(field_index == ngga_pkg::FIELD_MAX)
    && !$past(accept && char_data.sentence_end)
    |=> field_index == ngga_pkg::FIELD_MAX)
    else $error("field index left saturation");

  a_step: assert property (@(posedge clk) disable iff (rst)
    accept && !char_data.sentence_end && is_comma && field_index != ngga_pkg::FIELD_MAX
    |=> field_index == $past(field_index) + 4'd1)
    else $error("comma did not advance field index");

endmodule

// ===== sv/ngga_queue.sv =====
// ----------------------------------------------------------------------------
// ngga_queue
// Small register FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module ngga_queue #(
  parameter int unsigned Depth = ngga_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ngga_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ngga_pkg::item_t head_item
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ngga_pkg::item_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == FullCnt);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CntW'(1))
    else $error("queue count lost a push");

endmodule

// ===== sv/ngga_back.sv =====
// ----------------------------------------------------------------------------
// ngga_back
// Applies classified items to the accumulators and registers the result.
// ----------------------------------------------------------------------------
module ngga_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  ngga_pkg::item_t head_item,
  output logic            pop,
  output logic            fix_valid,
  input  logic            fix_stall,
  output ngga_pkg::fix_t  fix_data
);

  logic [31:0] time_acc;
  logic [31:0] lat_acc;
  logic [31:0] lon_acc;
  logic [7:0]  ns_letter;
  logic [7:0]  ew_letter;
  logic        bad_seen;
  logic [31:0] time_acc_next;
  logic [31:0] lat_acc_next;
  logic [31:0] lon_acc_next;
  logic [7:0]  ns_letter_next;
  logic [7:0]  ew_letter_next;
  logic        bad_seen_next;
  logic [31:0] sel_acc;
  logic [31:0] acc_step;
  logic [7:0]  digit_byte;
  logic        out_free;

  assign out_free = !fix_valid || !fix_stall;
  assign pop      = head_valid && (!head_item.last || out_free);

  always_comb begin
    unique case (head_item.op)
      ngga_pkg::OP_TIME: sel_acc = time_acc;
      ngga_pkg::OP_LAT:  sel_acc = lat_acc;
      default:           sel_acc = lon_acc;
    endcase
  end

  assign digit_byte = head_item.char_byte - ngga_pkg::CH_ZERO;
  assign acc_step   = (sel_acc << 3) + (sel_acc << 1) + {28'd0, digit_byte[3:0]};

  always_comb begin
    time_acc_next  = time_acc;
    lat_acc_next   = lat_acc;
    lon_acc_next   = lon_acc;
    ns_letter_next = ns_letter;
    ew_letter_next = ew_letter;
    bad_seen_next  = bad_seen;
    unique case (head_item.op)
      ngga_pkg::OP_TIME: time_acc_next  = acc_step;
      ngga_pkg::OP_LAT:  lat_acc_next   = acc_step;
      ngga_pkg::OP_LON:  lon_acc_next   = acc_step;
      ngga_pkg::OP_NS:   ns_letter_next = head_item.char_byte;
      ngga_pkg::OP_EW:   ew_letter_next = head_item.char_byte;
      ngga_pkg::OP_BAD:  bad_seen_next  = 1'b1;
      default:           bad_seen_next  = bad_seen;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_acc  <= '0;
      lat_acc   <= '0;
      lon_acc   <= '0;
      ns_letter <= '0;
      ew_letter <= '0;
      bad_seen  <= 1'b0;
    end else if (pop) begin
      if (head_item.last) begin
        time_acc  <= '0;
        lat_acc   <= '0;
        lon_acc   <= '0;
        ns_letter <= '0;
        ew_letter <= '0;
        bad_seen  <= 1'b0;
      end else begin
        time_acc  <= time_acc_next;
        lat_acc   <= lat_acc_next;
        lon_acc   <= lon_acc_next;
        ns_letter <= ns_letter_next;
        ew_letter <= ew_letter_next;
        bad_seen  <= bad_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid <= 1'b0;
    end else if (pop && head_item.last) begin
      fix_valid <= 1'b1;
    end else if (!fix_stall) begin
      fix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_item.last) begin
      fix_data.time_value      <= time_acc_next;
      fix_data.latitude_value  <= lat_acc_next;
      fix_data.north_south     <= ns_letter_next;
      fix_data.longitude_value <= lon_acc_next;
      fix_data.east_west       <= ew_letter_next;
      fix_data.fields_seen     <= head_item.fields_seen;
      fix_data.bad_character   <= bad_seen_next;
    end
  end

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.last |=> time_acc == '0 && lat_acc == '0 && lon_acc == '0
    && !bad_seen)
    else $error("state not cleared after sentence end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    fix_valid && fix_stall |-> !(pop && head_item.last))
    else $error("result overwritten while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    pop && head_item.last |=> fix_valid)
    else $error("sentence end produced no result");

endmodule

// ===== sv/nmea_gga_position_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_gga_position_parser
// GGA sentence parser: time, latitude, longitude and hemispheres per sentence.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the queue is not full; the x10
//   accumulate in the back end takes one queued character each cycle, except
//   that a sentence end waits while fix_stall holds the previous result.
// Reset: synchronous rst clears the field index, queue and accumulators.
// ----------------------------------------------------------------------------
module nmea_gga_position_parser #(
  parameter int unsigned QueueDepth = ngga_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            char_valid,
  output logic            char_stall,
  input  ngga_pkg::char_t char_data,
  output logic            fix_valid,
  input  logic            fix_stall,
  output ngga_pkg::fix_t  fix_data
);

  logic            accept;
  logic            q_full;
  logic            pop;
  logic            head_valid;
  ngga_pkg::item_t front_item;
  ngga_pkg::item_t head_item;

  assign char_stall = q_full;
  assign accept     = char_valid && !q_full;

  ngga_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_data (char_data),
    .item      (front_item)
  );

  ngga_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_item  (front_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ngga_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .fix_valid  (fix_valid),
    .fix_stall  (fix_stall),
    .fix_data   (fix_data)
  );

endmodule

// ===== dv/tb_nmea_gga_position_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_gga_position_parser
// Self-checking bench for the GGA sentence parser. A directed table covers
// empty sentences, a comma on the final beat, bad characters, unchecked
// hemisphere bytes and the saturating field count. Random sentences follow,
// mostly well formed with some broken or noisy ones. Both sides idle at
// random. Each fix is checked against a typed row fix or a behavioral parser.
// ----------------------------------------------------------------------------
module tb_nmea_gga_position_parser;

  localparam int CHAR_TARGET = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  typedef struct {
    ngga_pkg::char_t beat;
    bit              typed;
    ngga_pkg::fix_t  fix;
  } row_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            char_valid = 1'b0;
  logic            char_stall;
  ngga_pkg::char_t char_data = '0;
  logic            fix_valid;
  logic            fix_stall = 1'b0;
  ngga_pkg::fix_t  fix_data;

  logic [3:0]  field_idx = '0;
  logic [31:0] time_acc = '0;
  logic [31:0] lat_acc = '0;
  logic [31:0] lon_acc = '0;
  logic [7:0]  ns_letter = '0;
  logic [7:0]  ew_letter = '0;
  logic        bad_flag = 1'b0;

  ngga_pkg::fix_t  pending_fixes[$];
  ngga_pkg::fix_t  want_fix;
  ngga_pkg::char_t line_q[$];
  row_t            directed[$];
  int              mismatches = 0;
  int              n_chars = 0;
  int              quiet = 0;
  bit              calm = 1'b0;
  bit              hold_fix = 1'b0;

  nmea_gga_position_parser dut (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .fix_valid  (fix_valid),
    .fix_stall  (fix_stall),
    .fix_data   (fix_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] shift_in_digit(logic [31:0] acc, logic [7:0] ch);
    if (ch >= ngga_pkg::CH_ZERO && ch <= ngga_pkg::CH_NINE) begin
      return acc * 32'd10 + {24'd0, ch - ngga_pkg::CH_ZERO};
    end
    return acc;
  endfunction

  task automatic parse_char(input ngga_pkg::char_t beat, output bit done,
                            output ngga_pkg::fix_t fix);
    logic [7:0] ch;
    ch = beat.char_byte;
    if (ch == ngga_pkg::CH_COMMA) begin
      if (field_idx != ngga_pkg::FIELD_MAX) field_idx = field_idx + 4'd1;
    end else begin
      case (field_idx)
        ngga_pkg::FIELD_TIME: time_acc = shift_in_digit(time_acc, ch);
        ngga_pkg::FIELD_LAT:  lat_acc = shift_in_digit(lat_acc, ch);
        ngga_pkg::FIELD_NS:   ns_letter = ch;
        ngga_pkg::FIELD_LON:  lon_acc = shift_in_digit(lon_acc, ch);
        ngga_pkg::FIELD_EW:   ew_letter = ch;
        default: ;
      endcase
      if ((field_idx == ngga_pkg::FIELD_TIME || field_idx == ngga_pkg::FIELD_LAT ||
           field_idx == ngga_pkg::FIELD_LON) &&
          !(ch >= ngga_pkg::CH_ZERO && ch <= ngga_pkg::CH_NINE) &&
          ch != ngga_pkg::CH_DOT) bad_flag = 1'b1;
    end
    done = beat.sentence_end;
    fix = '{time_value: time_acc, latitude_value: lat_acc, north_south: ns_letter,
            longitude_value: lon_acc, east_west: ew_letter, fields_seen: field_idx,
            bad_character: bad_flag};
    if (done) begin
      field_idx = '0;
      time_acc = '0;
      lat_acc = '0;
      lon_acc = '0;
      ns_letter = '0;
      ew_letter = '0;
      bad_flag = 1'b0;
    end
  endtask

  task automatic send_beat(input ngga_pkg::char_t beat, input bit typed,
                           input ngga_pkg::fix_t typed_fix);
    bit             done;
    ngga_pkg::fix_t fix;
    while (!calm && $urandom_range(0, 99) < 29) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data <= beat;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    n_chars++;
    parse_char(beat, done, fix);
    if (done) pending_fixes.push_back(typed ? typed_fix : fix);
  endtask

  task automatic drain_fixes();
    char_valid <= 1'b0;
    do @(posedge clk); while (pending_fixes.size() != 0);
  endtask

  task automatic add_byte(input logic [7:0] ch);
    line_q.push_back('{char_byte: ch, sentence_end: 1'b0});
  endtask

  task automatic add_number();
    int n_dig;
    int dot_at;
    int bad_at;
    n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 8);
    dot_at = $urandom_range(0, n_dig + 2);
    bad_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, n_dig) : -1;
    for (int i = 0; i <= n_dig; i++) begin
      if (i == dot_at) add_byte(ngga_pkg::CH_DOT);
      if (i == bad_at) add_byte(8'($urandom_range(0, 255)));
      if (i < n_dig) add_byte(ngga_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_letter(input logic [7:0] a, input logic [7:0] b);
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 1) add_byte(8'($urandom_range(0, 255)));
    else if (pick > 1) add_byte(pick[0] ? a : b);
  endtask

  task automatic make_sentence();
    int              kind;
    ngga_pkg::char_t last;
    line_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 24))
        add_byte(($urandom_range(0, 3) == 0) ? ngga_pkg::CH_COMMA
                                             : 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(8'h41, 8'h5A)));
      add_byte(ngga_pkg::CH_COMMA);
      add_number();
      add_byte(ngga_pkg::CH_COMMA);
      add_number();
      add_byte(ngga_pkg::CH_COMMA);
      add_letter("N", "S");
      add_byte(ngga_pkg::CH_COMMA);
      add_number();
      add_byte(ngga_pkg::CH_COMMA);
      add_letter("E", "W");
      repeat ((kind == 1) ? $urandom_range(8, 14) : $urandom_range(0, 4)) begin
        add_byte(ngga_pkg::CH_COMMA);
        repeat ($urandom_range(0, 2)) add_byte(ngga_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1)) begin
        add_byte("*");
        add_byte(ngga_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        add_byte(ngga_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      // drop the tail of some sentences
      if (kind == 2) repeat ($urandom_range(0, line_q.size() - 1)) void'(line_q.pop_back());
    end
    last = line_q.pop_back();
    last.sentence_end = 1'b1;
    line_q.push_back(last);
  endtask

  function automatic row_t beat_row(logic [7:0] ch, logic last);
    return '{beat: '{char_byte: ch, sentence_end: last}, typed: 1'b0, fix: '0};
  endfunction

  function automatic row_t fix_row(logic [7:0] ch, logic [3:0] fields, logic bad);
    ngga_pkg::fix_t fix;
    fix = '0;
    fix.fields_seen = fields;
    fix.bad_character = bad;
    return '{beat: '{char_byte: ch, sentence_end: 1'b1}, typed: 1'b1, fix: fix};
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && fix_valid && !fix_stall) begin
      if (pending_fixes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: fix with none pending: %h", $time, fix_data);
      end else begin
        want_fix = pending_fixes.pop_front();
        check_field("time_value", want_fix.time_value, fix_data.time_value);
        check_field("latitude_value", want_fix.latitude_value, fix_data.latitude_value);
        check_field("north_south", 32'(want_fix.north_south), 32'(fix_data.north_south));
        check_field("longitude_value", want_fix.longitude_value, fix_data.longitude_value);
        check_field("east_west", 32'(want_fix.east_west), 32'(fix_data.east_west));
        check_field("fields_seen", 32'(want_fix.fields_seen), 32'(fix_data.fields_seen));
        check_field("bad_character", 32'(want_fix.bad_character),
                    32'(fix_data.bad_character));
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_fix) begin
        fix_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_fix = 1'b0;
      end else begin
        fix_stall <= !calm && ($urandom_range(0, 99) < 29);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (fix_valid && !fix_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    directed = '{fix_row(8'hFF, 4'd0, 1'b0), fix_row(ngga_pkg::CH_COMMA, 4'd1, 1'b0),
                 beat_row(ngga_pkg::CH_COMMA, 1'b0), fix_row(8'h00, 4'd1, 1'b1),
                 beat_row(ngga_pkg::CH_COMMA, 1'b0), beat_row("9", 1'b0),
                 beat_row(ngga_pkg::CH_DOT, 1'b0), beat_row("0", 1'b0),
                 beat_row(ngga_pkg::CH_COMMA, 1'b0), beat_row("9", 1'b0),
                 beat_row(ngga_pkg::CH_COMMA, 1'b0), beat_row(ngga_pkg::CH_DOT, 1'b0),
                 beat_row(ngga_pkg::CH_COMMA, 1'b0), beat_row("1", 1'b0),
                 beat_row(ngga_pkg::CH_COMMA, 1'b0), beat_row("W", 1'b0)};
    repeat (10) directed.push_back(beat_row(ngga_pkg::CH_COMMA, 1'b0));
    directed.push_back(beat_row(ngga_pkg::CH_COMMA, 1'b1));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_beat(directed[i].beat, directed[i].typed, directed[i].fix);
    drain_fixes();

    calm = 1'b1;
    repeat (10) begin
      make_sentence();
      foreach (line_q[i]) send_beat(line_q[i], 1'b0, '0);
    end
    calm = 1'b0;

    // hold the fix side while short sentences keep coming
    hold_fix = 1'b1;
    repeat (40) begin
      send_beat('{char_byte: ngga_pkg::CH_COMMA, sentence_end: 1'b0}, 1'b0, '0);
      send_beat('{char_byte: ngga_pkg::CH_ZERO + 8'($urandom_range(0, 9)),
                  sentence_end: 1'b1}, 1'b0, '0);
    end
    drain_fixes();

    while (n_chars < CHAR_TARGET) begin
      make_sentence();
      foreach (line_q[i]) send_beat(line_q[i], 1'b0, '0);
    end
    drain_fixes();

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
